// ===== src/wcbc_pkg.sv =====
// ----------------------------------------------------------------------------
// wcbc_pkg
// Shared constants and types for the Weibull chunk boundary check: table
// geometry, fixed-point constants, the table generator states and the
// write-port bundle from the generator to the table memory.
// ----------------------------------------------------------------------------
package wcbc_pkg;

    // Table geometry
    localparam int MAX_CHUNK = 16384;
    localparam int ADDR_W    = $clog2(MAX_CHUNK + 1);
    localparam int SIZE_W    = 15;
    localparam int HASH_W    = 32;
    localparam int CDF_W     = 32;

    // Sizes above this saturate the distribution outright
    localparam int N_LIMIT   = 16384;

    // Fixed-point constants (Q2.62 arithmetic)
    localparam logic [63:0]      Q62_ONE  = 64'h4000_0000_0000_0000;
    localparam logic [63:0]      Q_SAT    = 64'h0020_0000_0000_0000;
    localparam logic [63:0]      RND_HALF = 64'h0000_0000_2000_0000;
    localparam logic [63:0]      W_ONE    = 64'h0000_0001_0000_0000;
    localparam logic [CDF_W-1:0] CDF_SAT  = 32'hFFFF_FFFF;

    // Series length and number of squarings
    localparam int N_TERMS  = 8;
    localparam int N_SQUARE = 10;

    typedef enum logic [3:0] {
        G_SQ1,
        G_SQ2,
        G_CHK,
        G_MUL,
        G_MULD,
        G_DIV,
        G_SER,
        G_FIN,
        G_WR,
        G_DONE
    } t_gen_state;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [CDF_W-1:0]  data;
    } t_cdf_wr;

endpackage

// ===== src/wcbc_cdf_gen.sv =====
// ----------------------------------------------------------------------------
// wcbc_cdf_gen
// Computes the Weibull CDF table entry by entry after reset and streams each
// entry to the table memory. One shared 32x32 multiplier builds each Q2.62
// product from four partial products; a radix-256 small-divisor unit divides
// the series terms.
// ----------------------------------------------------------------------------
module wcbc_cdf_gen (
    input  logic              i_clk,
    input  logic              i_rst_n,
    output wcbc_pkg::t_cdf_wr o_wr,
    output logic              o_done
);
    import wcbc_pkg::*;

    t_gen_state r_state, n_state;

    logic [ADDR_W-1:0] r_n;
    logic [29:0]       r_n2;
    logic [59:0]       r_q;
    logic [63:0]       r_y;
    logic [63:0]       r_sum;
    logic [63:0]       r_ma;
    logic [63:0]       r_mb;
    logic [127:0]      r_acc;
    logic [63:0]       r_pp;
    logic [1:0]        r_ppi;
    logic [2:0]        r_k;
    logic [3:0]        r_i;
    logic [3:0]        r_sq;
    logic              r_squaring;
    logic [63:0]       r_dvd;
    logic [3:0]        r_rem;
    logic [2:0]        r_dstep;
    logic [CDF_W-1:0]  r_w;

    logic [31:0]  w_a_half;
    logic [31:0]  w_b_half;
    logic [63:0]  w_pp;
    logic [127:0] w_pp_sh;
    logic [63:0]  w_mres;
    logic [63:0]  w_div_q;
    logic [3:0]   w_div_rem;
    logic [63:0]  w_sum_next;
    logic [63:0]  w_tail;
    logic [63:0]  w_w64;
    logic [14:0]  w_n15;

    // Partial product order: lo*lo, lo*hi, hi*lo, hi*hi
    assign w_a_half = r_k[1] ? r_ma[63:32] : r_ma[31:0];
    assign w_b_half = r_k[0] ? r_mb[63:32] : r_mb[31:0];
    assign w_pp     = {32'd0, w_a_half} * {32'd0, w_b_half};
    assign w_mres   = r_acc[125:62];
    assign w_n15    = r_n[14:0];

    always_comb begin
        unique case (r_ppi)
            2'd0:    w_pp_sh = {64'd0, r_pp};
            2'd1,
            2'd2:    w_pp_sh = {32'd0, r_pp, 32'd0};
            default: w_pp_sh = {r_pp, 64'd0};
        endcase
    end

    // Eight restoring steps per cycle; divisor is at most eight
    always_comb begin
        logic [3:0]  rem;
        logic [63:0] dvd;
        rem = r_rem;
        dvd = r_dvd;
        for (int j = 0; j < 8; j++) begin
            rem = {rem[2:0], dvd[63]};
            dvd = {dvd[62:0], 1'b0};
            if (rem >= r_i) begin
                rem    = rem - r_i;
                dvd[0] = 1'b1;
            end
        end
        w_div_q   = dvd;
        w_div_rem = rem;
    end

    assign w_sum_next = r_i[0] ? (r_sum - r_dvd) : (r_sum + r_dvd);
    assign w_tail     = (r_sum + RND_HALF) >> 30;
    assign w_w64      = W_ONE - w_tail;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            G_SQ1:  n_state = (32'(r_n) > 32'(N_LIMIT)) ? G_WR : G_SQ2;
            G_SQ2:  n_state = G_CHK;
            G_CHK:  n_state = ({4'd0, r_q} >= Q_SAT) ? G_WR : G_MUL;
            G_MUL:  n_state = (r_k == 3'd4) ? G_MULD : G_MUL;
            G_MULD: begin
                if (!r_squaring) begin
                    n_state = G_DIV;
                end else if (r_sq == 4'(N_SQUARE - 1)) begin
                    n_state = G_FIN;
                end else begin
                    n_state = G_MUL;
                end
            end
            G_DIV:  n_state = (r_dstep == 3'd7) ? G_SER : G_DIV;
            G_SER:  n_state = G_MUL;
            G_FIN:  n_state = G_WR;
            G_WR:   n_state = (32'(r_n) == 32'(MAX_CHUNK)) ? G_DONE : G_SQ1;
            G_DONE: n_state = G_DONE;
            default: n_state = G_SQ1;
        endcase
    end

    // Outputs
    always_comb begin
        o_wr.en   = (r_state == G_WR);
        o_wr.addr = r_n;
        o_wr.data = r_w;
        o_done    = (r_state == G_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_SQ1;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == G_WR && n_state == G_SQ1) begin
                r_n <= r_n + 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            G_SQ1: begin
                r_n2 <= 30'({15'd0, w_n15} * {15'd0, w_n15});
                r_w  <= CDF_SAT;
            end
            G_SQ2: begin
                r_q <= {30'd0, r_n2} * {30'd0, r_n2};
            end
            G_CHK: begin
                r_y        <= {r_q, 4'd0};
                r_sum      <= Q62_ONE;
                r_ma       <= Q62_ONE;
                r_mb       <= {r_q, 4'd0};
                r_i        <= 4'd1;
                r_sq       <= '0;
                r_squaring <= 1'b0;
                r_k        <= '0;
                r_acc      <= '0;
            end
            G_MUL: begin
                if (r_k != 3'd4) begin
                    r_pp  <= w_pp;
                    r_ppi <= r_k[1:0];
                end
                if (r_k != 3'd0) begin
                    r_acc <= r_acc + w_pp_sh;
                end
                r_k <= r_k + 3'd1;
            end
            G_MULD: begin
                if (!r_squaring) begin
                    r_dvd   <= w_mres;
                    r_rem   <= '0;
                    r_dstep <= '0;
                end else begin
                    r_sum <= w_mres;
                    r_sq  <= r_sq + 4'd1;
                    r_ma  <= w_mres;
                    r_mb  <= w_mres;
                    r_k   <= '0;
                    r_acc <= '0;
                end
            end
            G_DIV: begin
                r_dvd   <= w_div_q;
                r_rem   <= w_div_rem;
                r_dstep <= r_dstep + 3'd1;
            end
            G_SER: begin
                r_sum <= w_sum_next;
                r_i   <= r_i + 4'd1;
                r_k   <= '0;
                r_acc <= '0;
                if (r_i == 4'(N_TERMS)) begin
                    // series done: square the sum
                    r_squaring <= 1'b1;
                    r_ma       <= w_sum_next;
                    r_mb       <= w_sum_next;
                end else begin
                    r_ma <= r_dvd;
                    r_mb <= r_y;
                end
            end
            G_FIN: begin
                r_w <= (w_w64 > {32'd0, CDF_SAT}) ? CDF_SAT : w_w64[31:0];
            end
            G_WR, G_DONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== src/weibull_chunk_boundary_check.sv =====
// ----------------------------------------------------------------------------
// weibull_chunk_boundary_check
// Content-defined chunk boundary decision from a Weibull size distribution.
// ----------------------------------------------------------------------------
// After reset the block builds its Weibull CDF table W(n), n = 0..MAX_CHUNK,
// in an internal memory and holds o_stall high until the table is complete.
// The table generator computes each entry with its shared 32x32 multiplier
// and series divider; entries from n = 9742 upward saturate and skip both.
// From then on it takes one item per cycle while the output is not stalled:
// each transfer reads W(size-item) and W(size) from the two read ports of
// the table memory, forms the division-free comparison, and returns one
// result through the stage 1, stage 2 and output registers. A stalled
// output freezes the whole pipeline; the input side sees o_stall then.
// ----------------------------------------------------------------------------
module weibull_chunk_boundary_check (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [wcbc_pkg::SIZE_W-1:0] i_chunk_size,
    input  logic [wcbc_pkg::SIZE_W-1:0] i_item_size,
    input  logic [wcbc_pkg::HASH_W-1:0] i_item_hash,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_boundary,
    output logic                        o_range_error
);
    import wcbc_pkg::*;

    // Table memory: written by the generator, read twice per item
    logic [CDF_W-1:0] r_cdf_mem [MAX_CHUNK + 1];

    t_cdf_wr w_wr;
    logic    w_gen_done;

    wcbc_cdf_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_wr    (w_wr),
        .o_done  (w_gen_done)
    );

    always_ff @(posedge i_clk) begin
        if (w_wr.en) begin
            r_cdf_mem[w_wr.addr] <= w_wr.data;
        end
    end

    // Output register contents
    logic r_o_valid;
    logic r_o_boundary;
    logic r_o_range_error;

    // Pipeline control: every stage moves unless the output is stalled
    logic w_adv;
    logic w_accept;

    assign w_adv    = !r_o_valid || !i_stall;
    assign o_stall  = !w_gen_done || !w_adv;
    assign w_accept = i_valid && !o_stall;

    // Stage 0: range check and table addresses
    logic              w_err;
    logic [SIZE_W-1:0] w_start;
    logic [ADDR_W-1:0] w_s_addr;
    logic [ADDR_W-1:0] w_e_addr;

    assign w_err    = (32'(i_chunk_size) > 32'(MAX_CHUNK)) || (i_item_size > i_chunk_size);
    assign w_start  = i_chunk_size - i_item_size;
    assign w_s_addr = ADDR_W'(w_start);
    assign w_e_addr = ADDR_W'(i_chunk_size);

    // Stage 1: table read data
    logic              r_s1_valid;
    logic              r_s1_err;
    logic [HASH_W-1:0] r_s1_hash;
    logic [CDF_W-1:0]  r_s1_cdf_s;
    logic [CDF_W-1:0]  r_s1_cdf_e;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_cdf_s <= r_cdf_mem[w_s_addr];
            r_s1_cdf_e <= r_cdf_mem[w_e_addr];
            r_s1_err   <= w_err;
            r_s1_hash  <= i_item_hash;
        end
    end

    // Stage 2: hash*(2^32-S) against (E-S)*(2^32-1)
    logic              w_sat;
    logic [CDF_W-1:0]  w_d;
    logic [CDF_W:0]    w_om;
    logic [64:0]       w_lhs;
    logic [63:0]       w_rhs;

    assign w_sat = (r_s1_cdf_s == CDF_SAT);
    assign w_d   = (r_s1_cdf_e > r_s1_cdf_s) ? (r_s1_cdf_e - r_s1_cdf_s) : '0;
    assign w_om  = {1'b1, {CDF_W{1'b0}}} - {1'b0, r_s1_cdf_s};
    assign w_lhs = {33'd0, r_s1_hash} * {32'd0, w_om};
    // D*(2^32-1) without a multiplier
    assign w_rhs = {w_d, 32'd0} - {32'd0, w_d};

    logic        r_s2_valid;
    logic        r_s2_err;
    logic        r_s2_sat;
    logic [63:0] r_s2_lhs;
    logic [63:0] r_s2_rhs;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_err <= r_s1_err;
            r_s2_sat <= w_sat;
            r_s2_lhs <= w_lhs[63:0];
            r_s2_rhs <= w_rhs;
        end
    end

    // Output register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_range_error <= r_s2_err;
            r_o_boundary    <= !r_s2_err && (r_s2_sat || (r_s2_lhs < r_s2_rhs));
        end
    end

    // Valid flags of every stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_accept;
            r_s2_valid <= r_s1_valid;
            r_o_valid  <= r_s2_valid;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_boundary    = r_o_boundary;
    assign o_range_error = r_o_range_error;

endmodule

// ===== tb/sv/weibull_chunk_boundary_check_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weibull_chunk_boundary_check_tb
// Self-checking bench for the Weibull chunk boundary check. It keeps its own
// copy of the Q0.32 CDF table, predicts boundary and range_error for every
// untyped transfer the block accepts, and checks results in order against
// that prediction or the typed verdict. A short table of directed probes
// comes first, then random items in four phases: no idling, idle input, stalled output, both.
// ----------------------------------------------------------------------------
module weibull_chunk_boundary_check_tb;

    import wcbc_pkg::*;

    // The table build after reset runs with no transfers; QUIET_LIMIT is set
    // above its length so the watchdog does not declare a hang during it.
    localparam int unsigned QUIET_LIMIT   = 6_000_000;
    localparam int          DRAIN_CYCLES  = 16;
    localparam int          ITEMS_PER_PHASE = 475;
    localparam int          REPORT_LIMIT  = 10;

    typedef struct packed {
        logic boundary;
        logic range_error;
    } t_verdict;

    // One directed probe: payload, and the verdict when it is obvious
    typedef struct packed {
        logic [SIZE_W-1:0] chunk;
        logic [SIZE_W-1:0] item;
        logic [HASH_W-1:0] hash;
        logic              typed;
        logic              boundary;
        logic              range_error;
    } t_probe;

    localparam int N_PROBES = 23;
    localparam t_probe PROBES [0:N_PROBES-1] = '{
        // empty chunk: W(0) is zero, no boundary
        '{15'd0,     15'd0,     32'h0000_0000, 1'b1, 1'b0, 1'b0},
        '{15'd0,     15'd0,     32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0},
        // whole chunk in one item: S = 0, E saturated
        '{15'd16384, 15'd16384, 32'h0000_0000, 1'b1, 1'b1, 1'b0},
        '{15'd16384, 15'd16384, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0},
        '{15'd16384, 15'd16384, 32'h0000_0001, 1'b0, 1'b0, 1'b0},
        // start point already saturated: boundary whatever the hash
        '{15'd16384, 15'd0,     32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0},
        '{15'd16384, 15'd1,     32'h0000_0000, 1'b0, 1'b0, 1'b0},
        // size out of range
        '{15'd16385, 15'd0,     32'h0000_0000, 1'b1, 1'b0, 1'b1},
        '{15'd32767, 15'd32767, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1},
        '{15'd32767, 15'd0,     32'h0000_0000, 1'b1, 1'b0, 1'b1},
        '{15'd0,     15'd1,     32'h0000_0000, 1'b1, 1'b0, 1'b1},
        '{15'd100,   15'd101,   32'h0000_0000, 1'b1, 1'b0, 1'b1},
        '{15'd16384, 15'd16385, 32'h0000_0000, 1'b1, 1'b0, 1'b1},
        // zero-width step below saturation: never a boundary
        '{15'd5000,  15'd0,     32'h0000_0000, 1'b1, 1'b0, 1'b0},
        '{15'd4096,  15'd0,     32'h0000_0000, 1'b1, 1'b0, 1'b0},
        // mid-curve and around the saturation knee
        '{15'd4096,  15'd64,    32'h0000_0000, 1'b0, 1'b0, 1'b0},
        '{15'd4096,  15'd64,    32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
        '{15'd8000,  15'd4000,  32'h1234_5678, 1'b0, 1'b0, 1'b0},
        '{15'd9741,  15'd1,     32'h0000_0000, 1'b0, 1'b0, 1'b0},
        '{15'd9742,  15'd1,     32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
        '{15'd12000, 15'd3000,  32'h8000_0000, 1'b0, 1'b0, 1'b0},
        '{15'd1,     15'd1,     32'h0000_0000, 1'b0, 1'b0, 1'b0},
        '{15'd2048,  15'd2048,  32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0}
    };

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic [SIZE_W-1:0] i_chunk_size  = '0;
    logic [SIZE_W-1:0] i_item_size   = '0;
    logic [HASH_W-1:0] i_item_hash   = '0;
    logic              i_stall       = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic              o_boundary;
    logic              o_range_error;

    // Side-band that travels with the payload: a typed verdict, if any
    logic     drive_typed = 1'b0;
    t_verdict drive_verdict = '0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;

    logic [CDF_W-1:0] cdf_q32 [0:MAX_CHUNK];
    t_verdict         pending_verdicts [$];

    weibull_chunk_boundary_check DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_chunk_size  (i_chunk_size),
        .i_item_size   (i_item_size),
        .i_item_hash   (i_item_hash),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_boundary    (o_boundary),
        .o_range_error (o_range_error)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // (a*b) >> 62 in Q2.62, kept to 64 bits
    function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // W(n) = 1 - exp(-(n/4096)^4) in Q0.32: truncated series for exp(-x/1024),
    // then ten squarings, then round and saturate
    function automatic logic [CDF_W-1:0] weibull_q32(input int unsigned n);
        logic [63:0] q;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] series;
        logic [63:0] w;
        int          k;
        if (n > N_LIMIT) begin
            return CDF_SAT;
        end
        q = 64'(n) * 64'(n);
        q = q * q;
        if (q >= Q_SAT) begin
            return CDF_SAT;
        end
        y      = q << 4;
        term   = Q62_ONE;
        series = Q62_ONE;
        for (k = 1; k <= N_TERMS; k++) begin
            term = q62_product(term, y) / 64'(k);
            if (k % 2 == 1) begin
                series = series - term;
            end else begin
                series = series + term;
            end
        end
        for (k = 0; k < N_SQUARE; k++) begin
            series = q62_product(series, series);
        end
        w = W_ONE - ((series + RND_HALF) >> 30);
        if (w > 64'(CDF_SAT)) begin
            w = 64'(CDF_SAT);
        end
        return w[CDF_W-1:0];
    endfunction

    // Division-free boundary decision: hash*(2^32-S) < (E-S)*(2^32-1)
    function automatic t_verdict predict_verdict(input logic [SIZE_W-1:0] chunk,
                                                 input logic [SIZE_W-1:0] item,
                                                 input logic [HASH_W-1:0] hash);
        t_verdict    v;
        logic [63:0] s;
        logic [63:0] e;
        logic [63:0] d;
        v = '0;
        if (chunk > MAX_CHUNK || item > chunk) begin
            v.range_error = 1'b1;
            return v;
        end
        s = 64'(cdf_q32[chunk - item]);
        e = 64'(cdf_q32[chunk]);
        if (s == 64'(CDF_SAT)) begin
            v.boundary = 1'b1;
            return v;
        end
        d = (e > s) ? e - s : 64'd0;
        v.boundary = (64'(hash) * (W_ONE - s)) < (d * 64'(CDF_SAT));
        return v;
    endfunction

    // Present one item, optionally after idle cycles, and hold it until the
    // block takes it. Only one assignment to i_valid lands in any time step.
    task automatic send_item(input logic [SIZE_W-1:0] chunk, input logic [SIZE_W-1:0] item,
                             input logic [HASH_W-1:0] hash, input logic typed,
                             input t_verdict verdict);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_chunk_size  <= chunk;
        i_item_size   <= item;
        i_item_hash   <= hash;
        drive_typed   <= typed;
        drive_verdict <= verdict;
        @(posedge i_clk);
        while (o_stall !== 1'b0) begin
            @(posedge i_clk);
        end
    endtask

    // Random item, weighted toward in-range sizes where the boundary odds
    // move quickly; the rest covers zero-width and full-chunk steps and out-of-range sizes.
    task automatic send_random_item();
        int unsigned       pick;
        logic [SIZE_W-1:0] chunk;
        logic [SIZE_W-1:0] item;
        logic [HASH_W-1:0] hash;
        pick = $urandom_range(0, 99);
        hash = $urandom;
        if ($urandom_range(0, 3) == 0) begin
            hash = hash >> $urandom_range(0, 31);
        end
        if (pick < 70) begin
            if ($urandom_range(0, 9) < 6) begin
                chunk = SIZE_W'($urandom_range(2048, 10000));
            end else begin
                chunk = SIZE_W'($urandom_range(0, MAX_CHUNK));
            end
            if ($urandom_range(0, 3) != 0) begin
                item = SIZE_W'($urandom_range(0, (chunk < 1024) ? chunk : 1024));
            end else begin
                item = SIZE_W'($urandom_range(0, chunk));
            end
        end else if (pick < 80) begin
            chunk = SIZE_W'($urandom_range(0, MAX_CHUNK));
            item  = ($urandom_range(0, 1) == 0) ? '0 : chunk;
        end else if (pick < 90) begin
            chunk = SIZE_W'($urandom_range(MAX_CHUNK + 1, 32767));
            item  = SIZE_W'($urandom_range(0, 32767));
        end else begin
            chunk = SIZE_W'($urandom_range(0, 32766));
            item  = SIZE_W'($urandom_range(chunk + 1, 32767));
        end
        send_item(chunk, item, hash, 1'b0, '0);
    endtask

    // Receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Record accepted inputs, check accepted results, and watch for a hang.
    // Inputs are recorded first so a same-cycle result still finds its entry.
    always @(posedge i_clk) begin : monitor
        t_verdict want;
        t_verdict seen;
        logic     moved;
        moved = 1'b0;
        if (i_valid && o_stall === 1'b0) begin
            moved = 1'b1;
            if (drive_typed) begin
                pending_verdicts.push_back(drive_verdict);
            end else begin
                pending_verdicts.push_back(predict_verdict(i_chunk_size, i_item_size,
                                                           i_item_hash));
            end
        end
        if (o_valid === 1'b1 && !i_stall) begin
            moved = 1'b1;
            seen  = '{o_boundary, o_range_error};
            if (pending_verdicts.size() == 0) begin
                if (mismatches < REPORT_LIMIT) begin
                    $display("result with nothing expected: boundary=%b range_error=%b",
                             seen.boundary, seen.range_error);
                end
                mismatches++;
            end else begin
                want = pending_verdicts.pop_front();
                if (seen !== want) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("mismatch: boundary exp %b got %b, range_error exp %b got %b",
                                 want.boundary, seen.boundary,
                                 want.range_error, seen.range_error);
                    end
                    mismatches++;
                end
            end
        end
        if (moved) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int p;
        int n;
        // Build the expected CDF table before anything is sent
        for (n = 0; n <= MAX_CHUNK; n++) begin
            cdf_q32[n] = weibull_q32(n);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed probes with no idling on either side
        for (p = 0; p < N_PROBES; p++) begin
            send_item(PROBES[p].chunk, PROBES[p].item, PROBES[p].hash, PROBES[p].typed,
                      '{PROBES[p].boundary, PROBES[p].range_error});
        end

        // Random phases: none, sender idle, receiver stall, both
        for (p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_random_item();
            end
        end
        i_valid <= 1'b0;

        // Drain: let every result out, then give the pipeline time to misbehave
        recv_stall_pct = 0;
        while (pending_verdicts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_verdicts.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
